// ----- design/indexed_insert_delete_array_assert.svh -----
// ----------------------------------------------------------------------------
// indexed_insert_delete_array assertion macros
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH

`ifndef SYNTHESIS
`define IIDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IIDA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IIDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define IIDA_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ----- design/iida_pkg.sv -----
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and codes of the indexed insert/delete array.
// ----------------------------------------------------------------------------
`default_nettype none

package iida_pkg;

  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_READ      = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_DELETE    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_PUT   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ----- design/indexed_insert_delete_array.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// Ordered word array with append, read, insert, overwrite and delete.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each transaction
// gives exactly one result, strobed by out_valid for one cycle in the cycle
// after the command completes, and the receiver cannot stall it. Append,
// overwrite, rejected commands and inserts/deletes that move nothing may
// follow back to back. An insert at index i moves entries i and up in
// S_SHIFT, then writes the new word in S_PUT; a delete moves the entries
// above i down in S_SHIFT. Entries move one per cycle through the single
// RAM write port. Storage sits in one RAM of CAPACITY words; entries are
// read only below the fill count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_insert_delete_array_assert.svh"

module indexed_insert_delete_array #(
  parameter int CAPACITY   = 32,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [iida_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [iida_pkg::INDEX_W-1:0]  in_index,
  input  wire logic [iida_pkg::VALUE_W-1:0]  in_value_in,
  output logic                               out_valid,
  output logic [iida_pkg::VALUE_W-1:0]       out_read_value,
  output logic [iida_pkg::COUNT_W-1:0]       out_count,
  output logic [iida_pkg::STATUS_W-1:0]      out_status
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > iida_pkg::INDEX_W) ? CW : iida_pkg::INDEX_W;

  iida_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     fill_count_r, fill_count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     lim_r, lim_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [iida_pkg::VALUE_W-1:0] out_read_value_r, out_read_value_nxt;
  iida_pkg::status_t          out_status_r, out_status_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CMPW-1:0]       idx_ext, fill_ext;
  logic [AW-1:0]         idx_a, fill_a, fill_m1_a, src_a;
  logic                  in_range, ins_ok, full, accept;
  logic [WORD_WIDTH-1:0] in_word;
  iida_pkg::cmd_t        cmd;

  iida_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != iida_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cmd       = iida_pkg::cmd_t'(in_cmd);
  assign idx_ext   = CMPW'(in_index);
  assign fill_ext  = CMPW'(fill_count_r);
  assign idx_a     = idx_ext[AW-1:0];
  assign fill_a    = fill_ext[AW-1:0];
  assign fill_m1_a = AW'(fill_count_r - 1'b1);
  assign in_range  = (idx_ext < fill_ext);
  assign ins_ok    = (idx_ext <= fill_ext);
  assign full      = (fill_count_r == CW'(CAPACITY));
  assign in_word   = WORD_WIDTH'(in_value_in);
  assign src_a     = dir_up_r ? (ptr_r - 1'b1) : (ptr_r + 1'b1);

  always_comb begin
    state_nxt          = state_r;
    fill_count_nxt     = fill_count_r;
    ptr_nxt            = ptr_r;
    lim_nxt            = lim_r;
    dir_up_nxt         = dir_up_r;
    word_nxt           = word_r;
    out_valid_nxt      = 1'b0;
    out_read_value_nxt = out_read_value_r;
    out_status_nxt     = out_status_r;
    ram_we             = 1'b0;
    ram_waddr          = idx_a;
    ram_wdata          = in_word;
    ram_re             = 1'b0;
    ram_raddr          = idx_a;

    case (state_r)
      iida_pkg::S_IDLE: begin
        if (accept) begin
          out_read_value_nxt = '0;
          out_status_nxt     = iida_pkg::ST_OK;
          out_valid_nxt      = 1'b1;
          case (cmd)
            iida_pkg::CMD_APPEND: begin
              if (full) begin
                out_status_nxt = iida_pkg::ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = fill_a;
                fill_count_nxt = fill_count_r + 1'b1;
              end
            end
            iida_pkg::CMD_READ: begin
              if (!in_range) begin
                out_status_nxt = iida_pkg::ST_RANGE;
              end else begin
                ram_re        = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = iida_pkg::S_READ;
              end
            end
            iida_pkg::CMD_INSERT: begin
              if (!ins_ok) begin
                out_status_nxt = iida_pkg::ST_RANGE;
              end else if (full) begin
                out_status_nxt = iida_pkg::ST_FULL;
              end else begin
                fill_count_nxt = fill_count_r + 1'b1;
                if (idx_ext == fill_ext) begin
                  ram_we = 1'b1;
                end else begin
                  ram_re        = 1'b1;
                  ram_raddr     = fill_a - 1'b1;
                  ptr_nxt       = fill_a;
                  lim_nxt       = idx_a;
                  dir_up_nxt    = 1'b1;
                  word_nxt      = in_word;
                  out_valid_nxt = 1'b0;
                  state_nxt     = iida_pkg::S_SHIFT;
                end
              end
            end
            iida_pkg::CMD_OVERWRITE: begin
              if (!in_range) begin
                out_status_nxt = iida_pkg::ST_RANGE;
              end else begin
                ram_we = 1'b1;
              end
            end
            iida_pkg::CMD_DELETE: begin
              if (!in_range) begin
                out_status_nxt = iida_pkg::ST_RANGE;
              end else begin
                fill_count_nxt = fill_count_r - 1'b1;
                if (idx_a != fill_m1_a) begin
                  ram_re        = 1'b1;
                  ram_raddr     = idx_a + 1'b1;
                  ptr_nxt       = idx_a;
                  lim_nxt       = fill_m1_a;
                  dir_up_nxt    = 1'b0;
                  out_valid_nxt = 1'b0;
                  state_nxt     = iida_pkg::S_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      iida_pkg::S_READ: begin
        out_valid_nxt      = 1'b1;
        out_read_value_nxt = iida_pkg::VALUE_W'(ram_rdata);
        out_status_nxt     = iida_pkg::ST_OK;
        state_nxt          = iida_pkg::S_IDLE;
      end
      iida_pkg::S_SHIFT: begin
        // rdata holds the entry at src_a; move it into ptr_r
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        if (src_a == lim_r) begin
          if (dir_up_r) begin
            state_nxt = iida_pkg::S_PUT;
          end else begin
            out_valid_nxt      = 1'b1;
            out_read_value_nxt = '0;
            out_status_nxt     = iida_pkg::ST_OK;
            state_nxt          = iida_pkg::S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dir_up_r ? (ptr_r - AW'(2)) : (ptr_r + AW'(2));
          ptr_nxt   = src_a;
        end
      end
      iida_pkg::S_PUT: begin
        ram_we             = 1'b1;
        ram_waddr          = lim_r;
        ram_wdata          = word_r;
        out_valid_nxt      = 1'b1;
        out_read_value_nxt = '0;
        out_status_nxt     = iida_pkg::ST_OK;
        state_nxt          = iida_pkg::S_IDLE;
      end
      default: begin
        state_nxt = iida_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= iida_pkg::S_IDLE;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r            <= ptr_nxt;
    lim_r            <= lim_nxt;
    dir_up_r         <= dir_up_nxt;
    word_r           <= word_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = iida_pkg::COUNT_W'(fill_count_r);
  assign out_status     = out_status_r;

  `IIDA_ASSERT(a_fill_bound, clk, rst_n, fill_count_r <= CW'(CAPACITY),
               "fill count above capacity")
  `IIDA_ASSERT(a_strobe_idle, clk, rst_n, out_valid |-> !busy,
               "result strobed while a transaction is still in progress")
  `IIDA_ASSERT(a_no_rw_clash, clk, rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr),
               "RAM read and write to the same entry in one cycle")
  `IIDA_ASSERT(a_full_status, clk, rst_n,
               (out_valid && out_status_r == iida_pkg::ST_FULL) |->
                 (fill_count_r == CW'(CAPACITY)),
               "full status reported while the array is not full")
  `IIDA_ASSERT_NORST(a_reset_quiet, clk, !rst_n |=> !out_valid,
                     "result strobe right after reset")

endmodule

`default_nettype wire

// ----- design/iida_ram.sv -----
// ----------------------------------------------------------------------------
// iida_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
